@@ rtl/core/rrbs_pkg.sv @@
package rrbs_pkg;

    localparam int NODES_DEF = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic in_valid;
        logic in_grant;
        logic pos_qual;
        logic pos_send;
        logic pend_valid;
        logic out_free;
        logic scan_end;
    } t_status;

    typedef struct packed {
        logic ready;
        logic grant_load;
        logic scan_start;
        logic push_out;
        logic take_pos;
        logic spend;
        logic advance;
        logic ptr_update;
        logic flush;
    } t_cmd;

endpackage

@@ rtl/core/rrbs_req_if.sv @@
interface rrbs_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [4:0]  dest;
    logic [15:0] burst_len;

    modport source (output valid, action, dest, burst_len, input ready);
    modport sink (input valid, action, dest, burst_len, output ready);
endinterface

@@ rtl/core/rrbs_res_if.sv @@
interface rrbs_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [4:0] target;
    logic       last;

    modport source (output valid, kind, target, last, input ready);
    modport sink (input valid, kind, target, last, output ready);
endinterface

@@ rtl/core/rrbs_ctrl.sv @@
module rrbs_ctrl
    import rrbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   stall;

    assign stall = i_status.pos_qual && i_status.pend_valid && !i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_status.in_valid && !i_status.in_grant) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = ST_FLUSH;
                end else if (!stall && i_status.pos_send) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_status.pend_valid || i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.ready      = 1'b1;
                o_cmd.grant_load = i_status.in_valid && i_status.in_grant;
                o_cmd.scan_start = i_status.in_valid && !i_status.in_grant;
            end
            ST_SCAN: begin
                if (i_status.scan_end) begin
                    o_cmd.ptr_update = 1'b1;
                end else if (!stall) begin
                    if (i_status.pos_qual) begin
                        o_cmd.push_out = i_status.pend_valid;
                        o_cmd.take_pos = 1'b1;
                    end
                    if (i_status.pos_send) begin
                        o_cmd.spend      = 1'b1;
                        o_cmd.ptr_update = 1'b1;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = i_status.pend_valid && i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/rrbs_datapath.sv @@
module rrbs_datapath
    import rrbs_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rrbs_req_if.sink      i_item,
    rrbs_res_if.source    o_result,
    input  t_cmd          i_cmd,
    output t_status       o_status
);

    localparam int RING = NODES - 1;
    localparam int PW   = $clog2(RING);
    localparam int CW   = $clog2(NODES + 1);

    logic [15:0]   r_credit [RING];
    logic          r_active [RING];
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_cnt;
    logic          r_pend_valid;
    logic          r_pend_kind;
    logic [4:0]    r_pend_target;
    logic          r_out_valid;
    logic          r_out_kind;
    logic [4:0]    r_out_target;
    logic          r_out_last;

    logic [15:0]   cur_credit;
    logic          cur_active;
    logic [15:0]   n_credit;
    logic [PW-1:0] pos_next;
    logic [PW+4:0] pos_wide;
    logic [PW+5:0] dest_wide;
    logic          dest_ok;
    logic [PW-1:0] dest_idx;

    assign cur_credit = r_credit[r_pos];
    assign cur_active = r_active[r_pos];
    assign n_credit   = cur_credit - 16'd1;
    assign pos_next   = (r_pos == PW'(RING - 1)) ? '0 : r_pos + PW'(1);
    assign pos_wide   = {5'b0, r_pos};
    assign dest_wide  = {(PW + 1)'(0), i_item.dest};
    assign dest_ok    = dest_wide < (PW + 6)'(RING);
    assign dest_idx   = dest_wide[PW-1:0];

    assign i_item.ready = i_cmd.ready;

    assign o_status.in_valid   = i_item.valid;
    assign o_status.in_grant   = i_item.action;
    assign o_status.pos_send   = cur_credit != 16'd0;
    assign o_status.pos_qual   = (cur_credit != 16'd0) || !cur_active;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = !r_out_valid || o_result.ready;
    assign o_status.scan_end   = r_cnt == CW'(NODES);

    assign o_result.valid  = r_out_valid;
    assign o_result.kind   = r_out_kind;
    assign o_result.target = r_out_target;
    assign o_result.last   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RING; k++) begin
                r_credit[k] <= '0;
                r_active[k] <= 1'b0;
            end
        end else if (i_cmd.grant_load && dest_ok) begin
            r_credit[dest_idx] <= i_item.burst_len;
            r_active[dest_idx] <= 1'b1;
        end else if (i_cmd.spend) begin
            r_credit[r_pos] <= n_credit;
            if (n_credit == 16'd0) begin
                r_active[r_pos] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_pos <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.scan_start) begin
                r_pos <= r_ptr;
                r_cnt <= '0;
            end else if (i_cmd.advance) begin
                r_pos <= pos_next;
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.ptr_update) begin
                r_ptr <= pos_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.take_pos) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.push_out || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pos) begin
            r_pend_kind   <= o_status.pos_send;
            r_pend_target <= pos_wide[4:0];
        end
        if (i_cmd.push_out || i_cmd.flush) begin
            r_out_kind   <= r_pend_kind;
            r_out_target <= r_pend_target;
            r_out_last   <= i_cmd.flush;
        end
    end

endmodule

@@ rtl/core/round_robin_burst_scheduler.sv @@
// Channel   Direction  Fields
// i_item    in         action (1), dest (5), burst_len (16)
// o_result  out        kind (1), target (5), last (1)
//
// A grant item gives no result.
// A tick item starts a scan at the pointer, steps through up to NODES ring
// positions, takes one more step when the scan runs through without a send,
// and then hands off its final pending result, if any; no new item is taken meanwhile.
// The scan stalls only when a new result meets a full output register.
// Synchronous active-low reset clears all credits, active marks and the pointer.
module round_robin_burst_scheduler
    import rrbs_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrbs_req_if.sink   i_item,
    rrbs_res_if.source o_result
);

    t_cmd    cmd;
    t_status status;

    rrbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rrbs_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule
